// File: hdl/sfpr_pkg.sv
// ----------------------------------------------------------------------------
// Segmented FIFO page replacement package
// Shared constants, register indexes and the control struct that the list
// controller hands to each frame cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpr_pkg;

   // Default list depth and page number width.
   localparam int FRAMES_DEF    = 64;
   localparam int PAGE_BITS_DEF = 20;

   // Configuration register widths and reset values.
   localparam int CSR_DATA_BITS  = 7;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_DATA_BITS-1:0] FRAMES_IN_USE_RESET = 7'd64;
   localparam logic [CSR_DATA_BITS-1:0] PRIMARY_SIZE_RESET  = 7'd32;

   // Width of the running totals.
   localparam int TOTAL_BITS = 32;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAMES_IN_USE = 1'b0,
      CSR_PRIMARY_SIZE  = 1'b1
   } csr_index_type;

   // Per-cell update command for one request.
   typedef struct packed {
      logic shift;      // take the entry of the neighbor in front
      logic set_dirty;  // mark the held page dirty in place
   } cell_ctl_type;

endpackage : sfpr_pkg

`default_nettype wire

// File: hdl/segmented_fifo_page_replacement.sv
// ----------------------------------------------------------------------------
// Segmented FIFO page replacement
// Ordered list of resident pages built as a row of frame cells. All cells
// match the request in parallel; misses insert at the front, and hits behind
// the primary boundary move the page to the front.
// ----------------------------------------------------------------------------
// The result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; the whole list updates at once.
// The request side stalls only while a finished result waits to be taken.
// Reset clears every valid and dirty bit, both totals and the result valid
// flag, and loads frames_in_use = 64 and primary_size = 32.
`default_nettype none

module segmented_fifo_page_replacement
   import sfpr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Configuration port.
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   // Request channel.
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [PAGE_BITS-1:0]      req_page_number,
   input  wire logic                      req_is_write,
   // Result channel.
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_fault,
   output logic                           rsp_promoted,
   output logic                           rsp_evicted_valid,
   output logic      [PAGE_BITS-1:0]      rsp_evicted_page,
   output logic                           rsp_writeback,
   output logic      [TOTAL_BITS-1:0]     rsp_fault_total,
   output logic      [TOTAL_BITS-1:0]     rsp_writeback_total
);

   // Width that holds both a register value and any list position + 1.
   localparam int IDX_BITS = $clog2(FRAMES + 1);
   localparam int LW = (IDX_BITS > CSR_DATA_BITS) ? IDX_BITS : CSR_DATA_BITS;

   // Configuration registers.
   logic [CSR_DATA_BITS-1:0] frames_in_use_ff, frames_in_use_in;
   logic [CSR_DATA_BITS-1:0] primary_size_ff, primary_size_in;

   always_comb begin
      frames_in_use_in = frames_in_use_ff;
      primary_size_in  = primary_size_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAMES_IN_USE: frames_in_use_in = csr_data;
            CSR_PRIMARY_SIZE:  primary_size_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= FRAMES_IN_USE_RESET;
         primary_size_ff  <= PRIMARY_SIZE_RESET;
      end else begin
         frames_in_use_ff <= frames_in_use_in;
         primary_size_ff  <= primary_size_in;
      end
   end

   // Effective capacity: zero acts as one, anything above the depth as the depth.
   logic [LW-1:0] limit;
   always_comb begin
      limit = LW'(frames_in_use_ff);
      if (limit == '0) begin
         limit = LW'(1);
      end else if (limit > LW'(FRAMES)) begin
         limit = LW'(FRAMES);
      end
   end

   // Handshake.
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Cell row.
   logic [PAGE_BITS-1:0] cell_page [FRAMES];
   logic [FRAMES-1:0]    cell_dirty;
   logic [FRAMES-1:0]    cell_valid;
   logic [FRAMES-1:0]    cell_match;
   cell_ctl_type         cell_ctl  [FRAMES];
   logic [PAGE_BITS-1:0] front_page;
   logic                 front_dirty;

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      sfpr_cell #(
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[g]),
         .key_page   (req_page_number),
         .prev_page  ((g == 0) ? front_page  : cell_page[(g == 0) ? 0 : g - 1]),
         .prev_dirty ((g == 0) ? front_dirty : cell_dirty[(g == 0) ? 0 : g - 1]),
         .prev_valid ((g == 0) ? 1'b1        : cell_valid[(g == 0) ? 0 : g - 1]),
         .page       (cell_page[g]),
         .dirty      (cell_dirty[g]),
         .valid      (cell_valid[g]),
         .match      (cell_match[g])
      );
   end

   // Per-position flags: last valid entry, capacity reached, behind boundary.
   logic [FRAMES-1:0] last_valid;
   logic [FRAMES-1:0] evict_sel;
   logic [FRAMES-1:0] beyond_primary;
   logic [FRAMES-1:0] at_or_before_hit;
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         if (i == FRAMES - 1) begin
            last_valid[i] = cell_valid[i];
         end else begin
            last_valid[i] = cell_valid[i] && !cell_valid[i + 1];
         end
         evict_sel[i]      = last_valid[i] && (LW'(i + 1) >= limit);
         beyond_primary[i] = LW'(i) >= LW'(primary_size_ff);
      end
      // A hit lies at or behind position i.
      at_or_before_hit[FRAMES-1] = cell_match[FRAMES-1];
      for (int i = FRAMES - 2; i >= 0; i--) begin
         at_or_before_hit[i] = cell_match[i] || at_or_before_hit[i + 1];
      end
   end

   // Request decode. Pages in the list are unique, so at most one cell matches.
   logic                 hit, miss, promote, evict, evict_dirty, hit_dirty;
   logic [PAGE_BITS-1:0] evict_page;
   always_comb begin
      hit         = |cell_match;
      miss        = !hit;
      promote     = hit && |(cell_match & beyond_primary);
      evict       = miss && |evict_sel;
      evict_dirty = evict && |(evict_sel & cell_dirty);
      hit_dirty   = |(cell_match & cell_dirty);
      evict_page  = '0;
      for (int i = 0; i < FRAMES; i++) begin
         evict_page = evict_page | (cell_page[i] & {PAGE_BITS{evict_sel[i] && evict}});
      end
   end

   // New front entry for an insert or a promotion.
   assign front_page  = req_page_number;
   assign front_dirty = req_is_write || (promote && hit_dirty);

   // Cell commands: a miss shifts the whole list except the free tail when
   // the last page is evicted; a promotion shifts the cells up to the hit.
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         if (i == 0) begin
            cell_ctl[i].shift = accept && (miss || promote);
         end else if (miss) begin
            cell_ctl[i].shift = accept && !(evict && !cell_valid[i]);
         end else begin
            cell_ctl[i].shift = accept && promote && at_or_before_hit[i];
         end
         cell_ctl[i].set_dirty = accept && hit && !promote && req_is_write && cell_match[i];
      end
   end

   // Saturating totals.
   logic [TOTAL_BITS-1:0] fault_count_ff, fault_count_in;
   logic [TOTAL_BITS-1:0] wb_count_ff, wb_count_in;
   always_comb begin
      fault_count_in = fault_count_ff;
      wb_count_in    = wb_count_ff;
      if (accept && miss && (fault_count_ff != '1)) begin
         fault_count_in = fault_count_ff + TOTAL_BITS'(1);
      end
      if (accept && evict_dirty && (wb_count_ff != '1)) begin
         wb_count_in = wb_count_ff + TOTAL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_count_ff <= '0;
         wb_count_ff    <= '0;
      end else begin
         fault_count_ff <= fault_count_in;
         wb_count_ff    <= wb_count_in;
      end
   end

   // Result register.
   logic                  fault_ff, promoted_ff, evicted_valid_ff, writeback_ff;
   logic [PAGE_BITS-1:0]  evicted_page_ff;
   logic [TOTAL_BITS-1:0] fault_total_ff, writeback_total_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fault_ff           <= miss;
         promoted_ff        <= promote;
         evicted_valid_ff   <= evict;
         evicted_page_ff    <= evict_page;
         writeback_ff       <= evict_dirty;
         fault_total_ff     <= fault_count_in;
         writeback_total_ff <= wb_count_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fault           = fault_ff;
   assign rsp_promoted        = promoted_ff;
   assign rsp_evicted_valid   = evicted_valid_ff;
   assign rsp_evicted_page    = evicted_page_ff;
   assign rsp_writeback       = writeback_ff;
   assign rsp_fault_total     = fault_total_ff;
   assign rsp_writeback_total = writeback_total_ff;

endmodule : segmented_fifo_page_replacement

`default_nettype wire

// File: hdl/sfpr_cell.sv
// ----------------------------------------------------------------------------
// Segmented FIFO page replacement frame cell
// Holds one list position: page number, dirty bit and valid bit. It compares
// its page against the request and takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpr_cell
   import sfpr_pkg::*;
#(
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_ctl_type         ctl,
   input  wire logic [PAGE_BITS-1:0] key_page,
   input  wire logic [PAGE_BITS-1:0] prev_page,
   input  wire logic                 prev_dirty,
   input  wire logic                 prev_valid,
   output logic      [PAGE_BITS-1:0] page,
   output logic                      dirty,
   output logic                      valid,
   output logic                      match
);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 dirty_ff, dirty_in;
   logic                 valid_ff, valid_in;

   // Next entry: shift from the neighbor, set dirty in place, or hold.
   always_comb begin
      page_in  = page_ff;
      dirty_in = dirty_ff;
      valid_in = valid_ff;
      if (ctl.shift) begin
         page_in  = prev_page;
         dirty_in = prev_dirty;
         valid_in = prev_valid;
      end else if (ctl.set_dirty) begin
         dirty_in = 1'b1;
      end
   end

   // The page number needs no reset; it is only used while valid is set.
   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         dirty_ff <= dirty_in;
         valid_ff <= valid_in;
      end
   end

   assign page  = page_ff;
   assign dirty = dirty_ff;
   assign valid = valid_ff;
   assign match = valid_ff && (page_ff == key_page);

endmodule : sfpr_cell

`default_nettype wire

// File: hdl/sfpr_check.sv
// ----------------------------------------------------------------------------
// Segmented FIFO page replacement port checker
// Watches the top level's ports and flags results that contradict each
// other; bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpr_check
   import sfpr_pkg::*;
#(
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic                      rsp_fault,
   input wire logic                      rsp_promoted,
   input wire logic                      rsp_evicted_valid,
   input wire logic [PAGE_BITS-1:0]      rsp_evicted_page,
   input wire logic                      rsp_writeback,
   input wire logic [TOTAL_BITS-1:0]     rsp_fault_total,
   input wire logic [TOTAL_BITS-1:0]     rsp_writeback_total
);

   // Only a miss can evict a page.
   a_evict_needs_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> rsp_fault)
      else $error("eviction reported on a hit");

   // A promotion is a hit, never a fault.
   a_promote_is_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_promoted |-> !rsp_fault)
      else $error("promotion reported on a fault");

   // Without an eviction there is no writeback and the page field is zero.
   a_no_evict_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> !rsp_writeback && (rsp_evicted_page == '0))
      else $error("writeback or page shown without an eviction");

   // A fault is counted, so the total cannot be zero.
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> (rsp_fault_total != '0))
      else $error("fault total is zero after a fault");

   // The request side is held only while a result is pending.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no pending result");

endmodule : sfpr_check

bind segmented_fifo_page_replacement sfpr_check #(
   .PAGE_BITS (PAGE_BITS)
) u_sfpr_check (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Segmented FIFO page replacement testbench
// Drives page accesses through the request channel under random idling and
// back-pressure. A scoreboard keeps its own copy of the resident page list.
// It predicts every result and checks it field by field. The run moves
// through several boundary and capacity settings, LRU and FIFO among them.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
   import sfpr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_FRAMES = FRAMES_DEF;
   localparam int PAGE_W     = PAGE_BITS_DEF;

   // One result of the block, in port order.
   typedef struct packed {
      logic                  fault;
      logic                  promoted;
      logic                  evicted_valid;
      logic [PAGE_W-1:0]     evicted_page;
      logic                  writeback;
      logic [TOTAL_BITS-1:0] fault_total;
      logic [TOTAL_BITS-1:0] writeback_total;
   } access_outcome_type;

   // Scoreboard: tracks the resident page list and the expected results.
   class replacement_scoreboard;
      logic [PAGE_W-1:0]      resident_page [NUM_FRAMES];
      bit                     resident_dirty [NUM_FRAMES];
      bit                     resident_valid [NUM_FRAMES];
      logic [TOTAL_BITS-1:0]  faults_so_far;
      logic [TOTAL_BITS-1:0]  writebacks_so_far;
      logic [CSR_DATA_BITS-1:0] capacity_reg;
      logic [CSR_DATA_BITS-1:0] boundary_reg;
      access_outcome_type     expected_outcomes [$];
      int failures;
      int checked;
      int accesses;
      int fault_hits;
      int promotions;
      int evictions;
      int dirty_evictions;

      function new();
         for (int i = 0; i < NUM_FRAMES; i++) begin
            resident_page[i]  = '0;
            resident_dirty[i] = 1'b0;
            resident_valid[i] = 1'b0;
         end
         faults_so_far     = '0;
         writebacks_so_far = '0;
         capacity_reg      = FRAMES_IN_USE_RESET;
         boundary_reg      = PRIMARY_SIZE_RESET;
         failures = 0;
         checked  = 0;
         accesses = 0;
         fault_hits = 0;
         promotions = 0;
         evictions  = 0;
         dirty_evictions = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_FRAMES_IN_USE: capacity_reg = value;
            CSR_PRIMARY_SIZE:  boundary_reg = value;
            default: ;
         endcase
      endfunction

      // Move entries 0..k-1 one place toward the back; entry k is overwritten.
      function void shift_toward_back(int k);
         for (int i = k; i > 0; i--) begin
            resident_page[i]  = resident_page[i-1];
            resident_dirty[i] = resident_dirty[i-1];
            resident_valid[i] = resident_valid[i-1];
         end
      endfunction

      // Update the list for one accepted request and queue its result.
      function void note_access(logic [PAGE_W-1:0] page, logic is_write);
         access_outcome_type outcome;
         int  length;
         int  capacity;
         int  pos;
         bit  hit;
         bit  was_dirty;
         outcome  = '0;
         accesses++;
         length = 0;
         while (length < NUM_FRAMES && resident_valid[length])
            length++;
         capacity = capacity_reg;
         if (capacity == 0)
            capacity = 1;
         if (capacity > NUM_FRAMES)
            capacity = NUM_FRAMES;
         hit = 1'b0;
         pos = 0;
         for (int i = 0; i < length && !hit; i++) begin
            if (resident_page[i] == page) begin
               hit = 1'b1;
               pos = i;
            end
         end
         if (!hit) begin
            // A miss inserts at the front, evicting the last page when full.
            outcome.fault = 1'b1;
            fault_hits++;
            if (faults_so_far != '1)
               faults_so_far++;
            if (length >= capacity) begin
               outcome.evicted_valid = 1'b1;
               outcome.evicted_page  = resident_page[length-1];
               outcome.writeback     = resident_dirty[length-1];
               evictions++;
               if (outcome.writeback) begin
                  dirty_evictions++;
                  if (writebacks_so_far != '1)
                     writebacks_so_far++;
               end
               resident_valid[length-1] = 1'b0;
               length--;
            end
            shift_toward_back(length);
            resident_page[0]  = page;
            resident_dirty[0] = is_write;
            resident_valid[0] = 1'b1;
         end else if (pos >= int'(boundary_reg)) begin
            // A hit in the secondary segment moves the page to the front.
            was_dirty = resident_dirty[pos];
            outcome.promoted = 1'b1;
            promotions++;
            shift_toward_back(pos);
            resident_page[0]  = page;
            resident_dirty[0] = was_dirty | is_write;
            resident_valid[0] = 1'b1;
         end else if (is_write) begin
            resident_dirty[pos] = 1'b1;
         end
         outcome.fault_total     = faults_so_far;
         outcome.writeback_total = writebacks_so_far;
         expected_outcomes.insert(expected_outcomes.size(), outcome);
      endfunction

      function void report_failure(string msg);
         failures++;
         if (failures <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
      endfunction

      // Compare one accepted result with the oldest expectation.
      function void check_outcome(access_outcome_type seen);
         access_outcome_type want;
         string bad;
         bad = "";
         if (expected_outcomes.size() == 0) begin
            report_failure($sformatf("unexpected result %p", seen));
            return;
         end
         want = expected_outcomes.pop_front();
         checked++;
         if (seen.fault !== want.fault)                 bad = {bad, " fault"};
         if (seen.promoted !== want.promoted)           bad = {bad, " promoted"};
         if (seen.evicted_valid !== want.evicted_valid) bad = {bad, " evicted_valid"};
         if (seen.evicted_page !== want.evicted_page)   bad = {bad, " evicted_page"};
         if (seen.writeback !== want.writeback)         bad = {bad, " writeback"};
         if (seen.fault_total !== want.fault_total)     bad = {bad, " fault_total"};
         if (seen.writeback_total !== want.writeback_total)
            bad = {bad, " writeback_total"};
         if (bad != "")
            report_failure($sformatf("result %0d differs in%s: expected %p, got %p",
                                     checked, bad, want, seen));
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write = 1'b0;
   csr_index_type             csr_index = CSR_FRAMES_IN_USE;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [PAGE_W-1:0]         req_page_number = '0;
   logic                      req_is_write = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_fault;
   logic                      rsp_promoted;
   logic                      rsp_evicted_valid;
   logic [PAGE_W-1:0]         rsp_evicted_page;
   logic                      rsp_writeback;
   logic [TOTAL_BITS-1:0]     rsp_fault_total;
   logic [TOTAL_BITS-1:0]     rsp_writeback_total;

   bit send_idling = 1'b1;
   bit recv_idling = 1'b1;
   int rsp_hold_left = 0;
   int settings_used = 0;

   replacement_scoreboard board = new();

   segmented_fifo_page_replacement i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_page_number     (req_page_number),
      .req_is_write        (req_is_write),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_fault           (rsp_fault),
      .rsp_promoted        (rsp_promoted),
      .rsp_evicted_valid   (rsp_evicted_valid),
      .rsp_evicted_page    (rsp_evicted_page),
      .rsp_writeback       (rsp_writeback),
      .rsp_fault_total     (rsp_fault_total),
      .rsp_writeback_total (rsp_writeback_total)
   );

   always #5 clock = ~clock;

   // Result side: check accepted results, then pick the next stall value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_outcome({rsp_fault, rsp_promoted, rsp_evicted_valid,
                              rsp_evicted_page, rsp_writeback,
                              rsp_fault_total, rsp_writeback_total});
      end
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (recv_idling) begin
         rsp_stall <= ($urandom_range(0, 99) < 35);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one request and wait until the block takes it. Entered at a
   // rising edge; valid stays high afterward unless the next call idles.
   task automatic send_request(input logic [PAGE_W-1:0] page, input logic is_write);
      int gap;
      gap = 0;
      if (send_idling)
         while ($urandom_range(0, 99) < 35)
            gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      req_is_write    <= is_write;
      do
         @(posedge clock);
      while (req_stall);
      board.note_access(page, is_write);
   endtask

   // Stop sending and let every expected result come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      board.set_register(idx, value[CSR_DATA_BITS-1:0]);
      settings_used++;
      @(posedge clock);
   endtask

   // Random accesses drawn mostly from a working set sized to the capacity,
   // so that hits, promotions and evictions all happen often.
   task automatic run_phase(input int frames, input int boundary, input int count,
                            input bit send_idle, input bit recv_idle,
                            input int hold, input bit pause_midway);
      logic [PAGE_W-1:0] working_set [$];
      logic [PAGE_W-1:0] page;
      int capacity;
      int set_size;
      int pick;
      wait_until_drained();
      write_register(CSR_FRAMES_IN_USE, frames);
      write_register(CSR_PRIMARY_SIZE, boundary);
      send_idling = send_idle;
      recv_idling = recv_idle;
      rsp_hold_left = hold;
      capacity = (frames == 0) ? 1 : ((frames > NUM_FRAMES) ? NUM_FRAMES : frames);
      set_size = $urandom_range(capacity / 2 + 1, capacity * 2 + 2);
      for (int k = 0; k < set_size; k++)
         working_set.insert(working_set.size(),
                            PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1)));
      for (int k = 0; k < count; k++) begin
         if (pause_midway && k == count / 2)
            wait_until_drained();
         pick = $urandom_range(0, 99);
         if (pick < 8)
            page = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
         else if (pick < 10)
            page = pick[0] ? '1 : '0;
         else
            page = working_set[$urandom_range(0, working_set.size() - 1)];
         send_request(page, $urandom_range(0, 99) < 40);
      end
   endtask

   // Main sequence.
   initial begin
      int waited;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting under the reset settings.
      send_request('0, 1'b1);
      send_request('1, 1'b0);
      wait_until_drained();
      write_register(CSR_FRAMES_IN_USE, 4);
      write_register(CSR_PRIMARY_SIZE, 2);
      send_request(20'h12345, 1'b0);
      send_request(20'hABCDE, 1'b1);   // list now full
      send_request('1, 1'b0);          // hit behind the boundary: promoted
      send_request(20'hABCDE, 1'b0);   // hit in the FIFO segment: no move
      send_request(20'h12345, 1'b1);   // promoted and marked dirty
      send_request(20'h55555, 1'b0);   // miss evicts a dirty page
      send_request(20'h2AAAA, 1'b1);   // miss evicts another dirty page
      send_request(20'h12345, 1'b0);   // promoted from behind the boundary
      send_request(20'h12345, 1'b0);   // already at the front
      wait_until_drained();
      // With no FIFO segment a hit at the front still counts as promoted.
      write_register(CSR_PRIMARY_SIZE, 0);
      send_request(20'h12345, 1'b1);
      send_request(20'h55555, 1'b0);
      wait_until_drained();
      // Capacity zero acts as one; the list keeps its length on a miss.
      write_register(CSR_FRAMES_IN_USE, 0);
      send_request(20'h00001, 1'b1);
      send_request(20'h00002, 1'b0);
      send_request(20'h55555, 1'b0);
      wait_until_drained();
      // Capacity above the list depth; boundary beyond the list blocks promotion.
      write_register(CSR_FRAMES_IN_USE, 127);
      write_register(CSR_PRIMARY_SIZE, 127);
      send_request(20'h2AAAA, 1'b0);
      send_request(20'h00003, 1'b1);
      send_request(20'h00001, 1'b0);

      // Random part over several settings, extremes first.
      run_phase(64, 0, 150, 1'b1, 1'b1, 0, 1'b0);     // LRU
      run_phase(64, 64, 150, 1'b1, 1'b1, 0, 1'b0);    // FIFO
      run_phase(8, 3, 150, 1'b0, 1'b0, 0, 1'b0);      // no idling at all
      run_phase(16, 8, 100, 1'b0, 1'b1, 300, 1'b1);   // long hold-off, then a pause
      run_phase(1, 0, 100, 1'b1, 1'b1, 0, 1'b0);
      run_phase(1, 1, 100, 1'b1, 1'b1, 0, 1'b0);
      run_phase(127, 127, 100, 1'b1, 1'b1, 0, 1'b0);
      run_phase(0, 0, 100, 1'b1, 1'b1, 0, 1'b0);
      run_phase(64, 32, 150, 1'b1, 1'b1, 0, 1'b0);
      repeat (4)
         run_phase($urandom_range(0, 127), $urandom_range(0, 127), 100,
                   1'b1, 1'b1, 0, 1'b0);

      // Wind down: collect the remaining results within a bounded time.
      req_valid <= 1'b0;
      waited = 0;
      while (board.pending() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      if (board.pending() != 0)
         board.report_failure($sformatf("%0d results never arrived", board.pending()));

      $display("Ran %0d requests under %0d register writes: %0d faults, %0d promotions,",
               board.accesses, settings_used, board.fault_hits, board.promotions);
      $display("%0d evictions of which %0d dirty; %0d results checked, %0d mismatches.",
               board.evictions, board.dirty_evictions, board.checked, board.failures);
      if (board.failures == 0) begin
         $display("PASS segmented_fifo_page_replacement");
      end else begin
         $display("FAIL segmented_fifo_page_replacement");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5ms;
      $display("Timeout: the run did not finish.");
      $display("FAIL segmented_fifo_page_replacement");
      $finish;
   end

endmodule : testbench

`default_nettype wire
